// ----- rtl/core/frustum_box_cull_defines.svh -----
// assertion macros for the checker file of the frustum box cull block
// depends on nothing; included by bare file name
`ifndef FRUSTUM_BOX_CULL_DEFINES_SVH
`define FRUSTUM_BOX_CULL_DEFINES_SVH

// property that must hold in the cycle after its trigger
`define FBC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// property that must hold in the same cycle as its trigger
`define FBC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/fbc_pkg.sv -----
// shared types and constants of the frustum box cull block
// depends on nothing
`default_nettype none

package fbc_pkg;

    // table depth default
    localparam int PLANE_COUNT_DEF = 6;

    // field widths
    localparam int IDX_W     = 3;
    localparam int NORMAL_W  = 16;
    localparam int COORD_W   = 32;
    localparam int OFFSET_W  = 32;

    // one table entry: three normal components and the offset
    localparam int PLANE_W   = 3 * NORMAL_W + OFFSET_W;

    // exact distance arithmetic
    localparam int PROD_W       = NORMAL_W + COORD_W;
    localparam int SUM_W        = PROD_W + 1;
    localparam int DIST_W       = SUM_W + 1;
    localparam int OFFSET_SHIFT = 14;
    localparam int OFFSET_PAD   = SUM_W - OFFSET_W - OFFSET_SHIFT;

    // item operations
    typedef enum logic [0:0] {
        OP_LOAD = 1'b0,
        OP_TEST = 1'b1
    } t_opcode;

endpackage

`default_nettype wire

// ----- rtl/core/fbc_ram.sv -----
// generic single-port-write, single-port-read ram with registered read data
// depends on nothing
`default_nettype none

module fbc_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 4,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/core/frustum_box_cull.sv -----
// frustum box cull top level: plane table in ram, per-plane distance pipeline
// depends on fbc_pkg and fbc_ram
//
//  channel | direction | handshake                   | payload
//  --------+-----------+-----------------------------+-------------------------------
//  in      | input     | i_in_valid / o_in_ready     | i_opcode .. i_box_max_z
//  out     | output    | o_out_valid / i_out_ready   | o_visible
//
// a load transaction writes the plane to ram at acceptance
// a test transaction holds the input off until its verdict is taken: one plane
//   is read from the table ram per cycle, then three pipeline stages finish
//   the last distance and the done state hands the verdict to the output register
// synchronous active-low reset empties the table (per-entry valid bits) at once
// the output register lets a new transaction in while a result waits; a test
//   that finishes while the output is still full waits until it drains
`default_nettype none

module frustum_box_cull
    import fbc_pkg::*;
#(
    parameter int PLANE_COUNT = PLANE_COUNT_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic                       i_opcode,
    input  wire logic [IDX_W-1:0]           i_plane_index,
    input  wire logic signed [NORMAL_W-1:0] i_normal_x,
    input  wire logic signed [NORMAL_W-1:0] i_normal_y,
    input  wire logic signed [NORMAL_W-1:0] i_normal_z,
    input  wire logic signed [OFFSET_W-1:0] i_plane_offset,
    input  wire logic signed [COORD_W-1:0]  i_box_min_x,
    input  wire logic signed [COORD_W-1:0]  i_box_min_y,
    input  wire logic signed [COORD_W-1:0]  i_box_min_z,
    input  wire logic signed [COORD_W-1:0]  i_box_max_x,
    input  wire logic signed [COORD_W-1:0]  i_box_max_y,
    input  wire logic signed [COORD_W-1:0]  i_box_max_z,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic                            o_visible
);

    localparam int AW = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   r_visible;
    logic   r_vis;

    // input transaction decode
    logic in_accept;
    logic load_acc;
    logic test_acc;
    logic in_range;

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_accept  = i_in_valid && o_in_ready;
    assign load_acc   = in_accept && (i_opcode == OP_LOAD);
    assign test_acc   = in_accept && (i_opcode == OP_TEST);
    assign in_range   = int'(i_plane_index) < PLANE_COUNT;

    // plane table ram and per-entry valid bits
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [PLANE_W-1:0]     ram_wdata;
    logic                   ram_re;
    logic [PLANE_W-1:0]     ram_rdata;
    logic [PLANE_COUNT-1:0] r_pvalid;
    logic [AW-1:0]          r_rd_idx;
    logic                   rd_last;

    assign ram_we    = load_acc && in_range;
    assign ram_waddr = AW'(i_plane_index);
    assign ram_wdata = {i_normal_x, i_normal_y, i_normal_z, i_plane_offset};
    assign ram_re    = (r_state == ST_RUN);
    assign rd_last   = (r_rd_idx == AW'(PLANE_COUNT - 1));

    fbc_ram #(
        .WIDTH (PLANE_W),
        .DEPTH (PLANE_COUNT),
        .ADDR_W(AW)
    ) u_plane_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(r_rd_idx),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvalid <= '0;
        end else if (ram_we) begin
            r_pvalid[ram_waddr] <= 1'b1;
        end
    end

    // box registers; per axis flag whether max is not below min
    logic signed [COORD_W-1:0] r_lo_x, r_lo_y, r_lo_z;
    logic signed [COORD_W-1:0] r_hi_x, r_hi_y, r_hi_z;
    logic                      r_ge_x, r_ge_y, r_ge_z;

    always_ff @(posedge i_clk) begin
        if (test_acc) begin
            r_lo_x <= i_box_min_x;
            r_lo_y <= i_box_min_y;
            r_lo_z <= i_box_min_z;
            r_hi_x <= i_box_max_x;
            r_hi_y <= i_box_max_y;
            r_hi_z <= i_box_max_z;
            r_ge_x <= (i_box_max_x >= i_box_min_x);
            r_ge_y <= (i_box_max_y >= i_box_min_y);
            r_ge_z <= (i_box_max_z >= i_box_min_z);
        end
    end

    // plane read counter
    always_ff @(posedge i_clk) begin
        if (test_acc) begin
            r_rd_idx <= '0;
        end else if (ram_re && !rd_last) begin
            r_rd_idx <= r_rd_idx + AW'(1);
        end
    end

    // pipeline control: read issued, products, partial sums
    logic r_v1, r_v2, r_v3;
    logic r_last1, r_last2, r_last3;
    logic r_pv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= ram_re;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_last1 <= rd_last;
        r_last2 <= r_last1;
        r_last3 <= r_last2;
        r_pv1   <= r_pvalid[r_rd_idx];
    end

    // stage 1: an entry never written reads as the zero plane
    logic [PLANE_W-1:0]         plane;
    logic signed [NORMAL_W-1:0] nx, ny, nz;
    logic signed [OFFSET_W-1:0] off;
    logic signed [COORD_W-1:0]  cx, cy, cz;

    assign plane = r_pv1 ? ram_rdata : '0;
    assign nx    = plane[PLANE_W-1 -: NORMAL_W];
    assign ny    = plane[PLANE_W-NORMAL_W-1 -: NORMAL_W];
    assign nz    = plane[OFFSET_W+NORMAL_W-1 -: NORMAL_W];
    assign off   = plane[OFFSET_W-1:0];

    // corner farthest along the normal: larger coordinate for a non-negative
    // component, smaller one otherwise
    assign cx = ((!nx[NORMAL_W-1]) == r_ge_x) ? r_hi_x : r_lo_x;
    assign cy = ((!ny[NORMAL_W-1]) == r_ge_y) ? r_hi_y : r_lo_y;
    assign cz = ((!nz[NORMAL_W-1]) == r_ge_z) ? r_hi_z : r_lo_z;

    logic signed [PROD_W-1:0]   r_px, r_py, r_pz;
    logic signed [OFFSET_W-1:0] r_off2;

    always_ff @(posedge i_clk) begin
        r_px   <= nx * cx;
        r_py   <= ny * cy;
        r_pz   <= nz * cz;
        r_off2 <= off;
    end

    // stage 2: two partial sums, offset scaled to the product format
    logic [SUM_W-1:0] r_sum_a, r_sum_b;

    always_ff @(posedge i_clk) begin
        r_sum_a <= {r_px[PROD_W-1], r_px} + {r_py[PROD_W-1], r_py};
        r_sum_b <= {r_pz[PROD_W-1], r_pz}
                 + {{OFFSET_PAD{r_off2[OFFSET_W-1]}}, r_off2, {OFFSET_SHIFT{1'b0}}};
    end

    // stage 3: largest corner distance, culled if below zero
    logic [DIST_W-1:0] corner_dist;
    logic              below;
    logic              r_cull;

    assign corner_dist = {r_sum_a[SUM_W-1], r_sum_a} + {r_sum_b[SUM_W-1], r_sum_b};
    assign below       = corner_dist[DIST_W-1];

    always_ff @(posedge i_clk) begin
        if (test_acc) begin
            r_cull <= 1'b0;
        end else if (r_v3) begin
            r_cull <= r_cull | below;
        end
    end

    // sequencer and output register
    logic out_load;

    assign out_load = (r_state == ST_DONE) && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (test_acc) begin
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (rd_last) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (r_v3 && r_last3) begin
                        r_vis   <= !(r_cull | below);
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_load) begin
                        r_visible <= r_vis;
                        r_state   <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_visible   = r_visible;

endmodule

`default_nettype wire

// ----- rtl/core/fbc_checker.sv -----
// port-level checker for the frustum box cull top level, bound to it below
// depends on fbc_pkg and frustum_box_cull_defines.svh
`default_nettype none
`include "frustum_box_cull_defines.svh"

module fbc_checker
    import fbc_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic o_in_ready,
    input wire logic i_opcode,
    input wire logic o_out_valid,
    input wire logic i_out_ready,
    input wire logic o_visible
);

    logic in_acc;

    assign in_acc = i_in_valid && o_in_ready;

    // a waiting result stays offered
    `FBC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid, "result dropped while stalled")

    // a waiting result keeps its value
    `FBC_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready, $stable(o_visible), "result changed while stalled")

    // a test transaction occupies the block for the next cycle
    `FBC_ASSERT_NEXT(a_test_busy, i_clk, i_rst_n, in_acc && (i_opcode == OP_TEST), !o_in_ready, "input taken during a test")

    // a load transaction never yields a result
    `FBC_ASSERT_NEXT(a_load_silent, i_clk, i_rst_n, in_acc && (i_opcode == OP_LOAD), !$rose(o_out_valid), "result after a load")

endmodule

bind frustum_box_cull fbc_checker u_fbc_checker (.*);

`default_nettype wire
